[rtl/core/qasu_pkg.sv]
// qasu_pkg: request codes, configuration indices and payload types of the spin-update block
// no dependencies

package qasu_pkg;

	localparam logic [2:0] REQ_WR_COUPLING = 3'd0;
	localparam logic [2:0] REQ_WR_FIELD    = 3'd1;
	localparam logic [2:0] REQ_WR_SPIN     = 3'd2;
	localparam logic [2:0] REQ_UPDATE      = 3'd3;
	localparam logic [2:0] REQ_RD_SPIN     = 3'd4;

	localparam logic [1:0] CFG_TROTTER_COUNT = 2'd0;
	localparam logic [1:0] CFG_SPIN_COUNT    = 2'd1;
	localparam logic [1:0] CFG_TRANSVERSE    = 2'd2;
	localparam logic [1:0] CFG_INV_TEMP      = 2'd3;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [3:0]         trotter_index;
		logic [5:0]         spin_index;
		logic [5:0]         column_index;
		logic signed [15:0] value;
		logic signed [31:0] log_rand;
	} req_t;

	typedef struct packed {
		logic spin_value;
		logic flipped;
		logic status;
	} rsp_t;

endpackage

[rtl/core/quantum_annealing_spin_update.sv]
// quantum_annealing_spin_update: metropolis spin flip over a chain of spin cells
// writes go to S_DONE, spin reads via S_ROW, updates run S_ROW through S_CMP
// throughput: one item at a time, an update is bound by one coupling read per spin
// the next item is taken while a result waits in the output register
// reset clears configuration and control; spin, coupling and field stores are not cleared
// depends on qasu_pkg and qasu_cell

module quantum_annealing_spin_update #(
	parameter int MAX_TROTTERS = 16,
	parameter int MAX_SPINS    = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_wdata,
	input  logic           req_valid,
	output logic           req_ready,
	input  qasu_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output qasu_pkg::rsp_t rsp
);

	import qasu_pkg::*;

	localparam int TW  = (MAX_TROTTERS > 1) ? $clog2(MAX_TROTTERS) : 1;
	localparam int SW  = (MAX_SPINS > 1) ? $clog2(MAX_SPINS) : 1;
	localparam int AW  = 16 + SW + 1;
	localparam int DW  = ((AW > 22) ? AW : 22) + 1;
	localparam int HW  = DW + 2;
	localparam int EW  = HW + 2;
	localparam int PW  = EW + 17;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ROW   = 4'd1;
	localparam logic [3:0] S_UP    = 4'd2;
	localparam logic [3:0] S_DN    = 4'd3;
	localparam logic [3:0] S_ACC   = 4'd4;
	localparam logic [3:0] S_DRAIN = 4'd5;
	localparam logic [3:0] S_SUM   = 4'd6;
	localparam logic [3:0] S_MUL   = 4'd7;
	localparam logic [3:0] S_CMP   = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [4:0]         trotter_count_q;
	logic [6:0]         spin_count_q;
	logic signed [15:0] jperp_q;
	logic [15:0]        beta_q;

	logic [3:0] state_q;
	logic [2:0] type_q;
	logic [3:0] m_q;
	logic [5:0] i_q;
	logic signed [31:0] lr_q;
	logic [6:0] j_q;
	rsp_t res_q;
	rsp_t out_q;
	logic out_valid_q;

	logic [MAX_SPINS-1:0] spin_mem [MAX_TROTTERS];
	logic signed [15:0]   coup_mem [MAX_SPINS*MAX_SPINS];
	logic signed [15:0]   field_mem [MAX_SPINS];
	logic [MAX_SPINS-1:0] row_q;
	logic signed [15:0]   cdata_s1;
	logic signed [15:0]   field_q;
	logic                 sbit_s1;
	logic                 acc_v_s1;

	logic self_q, su_q, sd_q;
	logic signed [21:0] tun_q;
	logic signed [AW-1:0] acc_q;
	logic signed [EW-1:0] e_q;
	logic signed [PW-1:0] prod_q;

	logic [4:0] nt;
	logic [6:0] ns;
	logic       accept;
	logic       req_err;
	logic [4:0] up_idx, dn_idx;
	logic [TW-1:0] sp_raddr;
	logic [MAX_SPINS-1:0] chain;
	logic       chain_load, chain_shift;
	logic signed [DW-1:0] dh0;
	logic signed [HW-1:0] tsum;
	logic signed [EW-1:0] e_next;
	logic signed [PW:0]   neg_prod;
	logic       flip;
	logic       sp_we;
	logic [TW-1:0] sp_waddr;
	logic [SW-1:0] sp_wcol;
	logic       sp_wbit;

	assign nt = (32'(trotter_count_q) > MAX_TROTTERS) ? 5'(MAX_TROTTERS) : trotter_count_q;
	assign ns = (32'(spin_count_q) > MAX_SPINS) ? 7'(MAX_SPINS) : spin_count_q;
	assign req_ready = (state_q == S_IDLE);
	assign accept = req_valid && req_ready;

	always_comb begin
		case (req.req_type)
			REQ_WR_COUPLING: req_err = ({1'b0, req.spin_index} >= ns) ||
				({1'b0, req.column_index} >= ns);
			REQ_WR_FIELD: req_err = ({1'b0, req.spin_index} >= ns);
			REQ_WR_SPIN, REQ_UPDATE, REQ_RD_SPIN: req_err =
				({1'b0, req.trotter_index} >= nt) || ({1'b0, req.spin_index} >= ns);
			default: req_err = 1'b1;
		endcase
	end

	assign up_idx = (m_q == 4'd0) ? nt - 5'd1 : {1'b0, m_q} - 5'd1;
	assign dn_idx = ({1'b0, m_q} == nt - 5'd1) ? 5'd0 : {1'b0, m_q} + 5'd1;

	always_comb begin
		case (state_q)
			S_ROW:   sp_raddr = TW'(up_idx);
			S_UP:    sp_raddr = TW'(dn_idx);
			default: sp_raddr = TW'(req.trotter_index);
		endcase
	end

	// spin store, one row per trotter
	assign sp_we = (accept && req.req_type == REQ_WR_SPIN && !req_err) ||
		(state_q == S_CMP && flip);
	assign sp_waddr = (state_q == S_CMP) ? TW'(m_q) : TW'(req.trotter_index);
	assign sp_wcol = (state_q == S_CMP) ? SW'(i_q) : SW'(req.spin_index);
	assign sp_wbit = (state_q == S_CMP) ? !self_q : req.value[0];

	always_ff @(posedge clk) begin
		if (sp_we) begin
			spin_mem[sp_waddr][sp_wcol] <= sp_wbit;
		end
		row_q <= spin_mem[sp_raddr];
	end

	always_ff @(posedge clk) begin
		if (accept && req.req_type == REQ_WR_COUPLING && !req_err) begin
			coup_mem[{SW'(req.spin_index), SW'(req.column_index)}] <= req.value;
		end
		cdata_s1 <= coup_mem[{SW'(i_q), SW'(j_q)}];
	end

	always_ff @(posedge clk) begin
		if (accept && req.req_type == REQ_WR_FIELD && !req_err) begin
			field_mem[SW'(req.spin_index)] <= req.value;
		end
		field_q <= field_mem[SW'(i_q)];
	end

	// spin chain, cell 0 feeds the accumulator
	assign chain_load = (state_q == S_ROW);
	assign chain_shift = (state_q == S_ACC);

	for (genvar k = 0; k < MAX_SPINS; k++) begin : g_cell
		qasu_cell u_cell (
			.clk      (clk),
			.load     (chain_load),
			.load_bit (row_q[k]),
			.shift    (chain_shift),
			.next_bit ((k == MAX_SPINS - 1) ? 1'b0 : chain[(k + 1) % MAX_SPINS]),
			.bit_q    (chain[k])
		);
	end

	always_comb begin
		dh0 = DW'(acc_q);
		if (su_q == sd_q) begin
			dh0 = su_q ? dh0 - DW'(tun_q) : dh0 + DW'(tun_q);
		end
		tsum = (HW'(dh0) <<< 1) + HW'(field_q);
		e_next = self_q ? -(EW'(tsum) <<< 1) : (EW'(tsum) <<< 1);
	end

	assign neg_prod = -((PW + 1)'(prod_q));
	assign flip = (neg_prod > (PW + 1)'(lr_q));

	always_ff @(posedge clk) begin
		if (accept) begin
			type_q <= req.req_type;
			m_q <= req.trotter_index;
			i_q <= req.spin_index;
			lr_q <= req.log_rand;
		end
		sbit_s1 <= chain[0];
		case (state_q)
			S_ROW: begin
				self_q <= row_q[SW'(i_q)];
				tun_q <= 22'(jperp_q * $signed({1'b0, nt}));
			end
			S_UP: su_q <= row_q[SW'(i_q)];
			S_DN: begin
				sd_q <= row_q[SW'(i_q)];
				acc_q <= '0;
			end
			S_SUM: e_q <= e_next;
			S_MUL: prod_q <= PW'($signed({1'b0, beta_q}) * e_q);
			default: ;
		endcase
		if (acc_v_s1) begin
			acc_q <= sbit_s1 ? acc_q + AW'(cdata_s1) : acc_q - AW'(cdata_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trotter_count_q <= 5'd16;
			spin_count_q <= 7'd64;
			jperp_q <= '0;
			beta_q <= 16'd4096;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TROTTER_COUNT: trotter_count_q <= cfg_wdata[4:0];
				CFG_SPIN_COUNT:    spin_count_q <= cfg_wdata[6:0];
				CFG_TRANSVERSE:    jperp_q <= $signed(cfg_wdata);
				CFG_INV_TEMP:      beta_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			j_q <= '0;
			acc_v_s1 <= 1'b0;
			res_q <= '0;
			out_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			acc_v_s1 <= (state_q == S_ACC);
			if (out_valid_q && rsp_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q <= '{spin_value: req.req_type == REQ_WR_SPIN && !req_err &&
							req.value[0], flipped: 1'b0, status: req_err};
						if (!req_err && (req.req_type == REQ_UPDATE ||
							req.req_type == REQ_RD_SPIN)) begin
							state_q <= S_ROW;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_ROW: begin
					if (type_q == REQ_RD_SPIN) begin
						res_q <= '{spin_value: row_q[SW'(i_q)], flipped: 1'b0, status: 1'b0};
						state_q <= S_DONE;
					end else begin
						state_q <= S_UP;
					end
				end
				S_UP: state_q <= S_DN;
				S_DN: begin
					j_q <= '0;
					state_q <= S_ACC;
				end
				S_ACC: begin
					j_q <= j_q + 7'd1;
					if (j_q == ns - 7'd1) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_SUM;
				S_SUM:   state_q <= S_MUL;
				S_MUL:   state_q <= S_CMP;
				S_CMP: begin
					res_q <= '{spin_value: flip ? !self_q : self_q, flipped: flip, status: 1'b0};
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || rsp_ready) begin
						out_q <= res_q;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	a_acc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ACC |-> j_q < ns)
		else $error("coupling index past spin count");
	a_acc_window: assert property (@(posedge clk) disable iff (!arst_n)
		acc_v_s1 |-> (state_q == S_ACC || state_q == S_DRAIN))
		else $error("accumulate outside sweep");
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q) == S_DONE)
		else $error("result without finished item");
	a_cmp_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |=> state_q == S_DONE)
		else $error("compare did not finish item");

endmodule

[rtl/core/qasu_cell.sv]
// qasu_cell: one spin bit of the shift chain that feeds the field accumulator
// depends on nothing

module qasu_cell (
	input  logic clk,
	input  logic load,
	input  logic load_bit,
	input  logic shift,
	input  logic next_bit,
	output logic bit_q
);

	always_ff @(posedge clk) begin
		if (load) begin
			bit_q <= load_bit;
		end else if (shift) begin
			bit_q <= next_bit;
		end
	end

endmodule
